// ===== sv/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
`timescale 1ns / 1ps

package lpd_pkg;

   localparam int BYTE_W   = 8;
   localparam int FLEN_W   = 7;   // width of the reported frame length
   localparam int HDR_LEN_W = 16; // width of the length field in the header

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_CLEAR = 1'b1
   } lpd_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } lpd_state_type;

endpackage

// ===== sv/lpd_channels.sv =====
// Valid/ready channel interfaces for the deframer input and result streams.
`timescale 1ns / 1ps

interface lpd_req_if;
   import lpd_pkg::*;

   logic                valid;
   logic                ready;
   lpd_cmd_type         command;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface lpd_rsp_if;
   import lpd_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   frame_byte;
   logic [FLEN_W-1:0]   frame_length;
   logic                is_last;

   modport source (output valid, output frame_byte, output frame_length,
                   output is_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_length,
                   input is_last, output ready);
endinterface

// ===== sv/length_prefixed_deframer.sv =====
// Top level: a push or clear command is taken while no frame is being replayed.
// A completed frame is replayed byte by byte once its final byte is transferred: each byte
// takes a read of the store's single read port, then a load of the output register, which
// waits while the output is stalled; input is held off during replay.
// Reset is synchronous: it empties the receiver and the output register; the store is not
// cleared, as every byte read back was written within the current frame.
`timescale 1ns / 1ps

module length_prefixed_deframer #(
   parameter int BUFFER_BYTES = 64,
   parameter int HEADER_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   lpd_req_if.sink    req_if,
   lpd_rsp_if.source  rsp_if
);
   import lpd_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;

   lpd_ctrl #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .AW           (AW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lpd_frame_mem #(
      .DEPTH (BUFFER_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== sv/lpd_frame_mem.sv =====
// Frame byte store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lpd_frame_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [lpd_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [lpd_pkg::BYTE_W-1:0] rd_data
);
   import lpd_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lpd_ctrl.sv =====
// Byte counting, header check and frame replay sequencer with output register.
`timescale 1ns / 1ps

module lpd_ctrl #(
   parameter int BUFFER_BYTES = 64,
   parameter int HEADER_BYTES = 4,
   parameter int AW           = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   lpd_req_if.sink                    req_if,
   lpd_rsp_if.source                  rsp_if,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic [lpd_pkg::BYTE_W-1:0] wr_data,
   output logic [AW-1:0]              rd_addr,
   input  logic [lpd_pkg::BYTE_W-1:0] rd_data
);
   import lpd_pkg::*;

   localparam int CW = $clog2(BUFFER_BYTES + 1);

   lpd_state_type        state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [BYTE_W-1:0]    len_lo_ff, len_lo_in;
   logic [BYTE_W-1:0]    len_hi_ff, len_hi_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic [FLEN_W-1:0]    out_len_ff, out_len_in;
   logic                 out_last_ff, out_last_in;

   logic                 req_fire;
   logic                 full;
   logic [CW-1:0]        base_cnt;
   logic [CW-1:0]        cnt_new;
   logic [HDR_LEN_W-1:0] len_now;
   logic [HDR_LEN_W-1:0] len_stored;
   logic                 out_free;
   logic                 rd_is_last;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   // The length checks keep the count from reaching a full buffer.
   assign full     = (count_ff >= CW'(BUFFER_BYTES));
   assign base_cnt = full ? '0 : count_ff;
   assign cnt_new  = base_cnt + CW'(1);

   // Header length as it stands once this byte is stored.
   assign len_now = {(base_cnt == CW'(1)) ? req_if.rx_byte : len_hi_ff,
                     (base_cnt == CW'(0)) ? req_if.rx_byte : len_lo_ff};
   assign len_stored = {len_hi_ff, len_lo_ff};

   assign out_free   = !out_valid_ff || rsp_if.ready;
   assign rd_is_last = ((HDR_LEN_W'(rd_addr_ff) + HDR_LEN_W'(1)) == len_stored);

   assign wr_en   = req_fire && (req_if.command == CMD_PUSH);
   assign wr_addr = base_cnt[AW-1:0];
   assign wr_data = req_if.rx_byte;
   assign rd_addr = rd_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_lo_ff   <= len_lo_in;
      len_hi_ff   <= len_hi_in;
      rd_addr_ff  <= rd_addr_in;
      out_byte_ff <= out_byte_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_lo_in    = len_lo_ff;
      len_hi_in    = len_hi_ff;
      rd_addr_in   = rd_addr_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_byte_in  = out_byte_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.command == CMD_CLEAR) begin
                  count_in = '0;
               end else begin
                  count_in  = cnt_new;
                  len_lo_in = len_now[BYTE_W-1:0];
                  len_hi_in = len_now[HDR_LEN_W-1:BYTE_W];
                  if (cnt_new >= CW'(HEADER_BYTES)) begin
                     if (len_now < HDR_LEN_W'(HEADER_BYTES) ||
                         len_now > HDR_LEN_W'(BUFFER_BYTES)) begin
                        count_in = '0;
                     end else if (HDR_LEN_W'(cnt_new) >= len_now) begin
                        count_in   = '0;
                        rd_addr_in = '0;
                        state_in   = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            // Read address is presented this cycle; data is back next cycle.
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = rd_data;
               out_len_in   = len_stored[FLEN_W-1:0];
               out_last_in  = rd_is_last;
               if (rd_is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr_in = rd_addr_ff + AW'(1);
                  state_in   = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.frame_byte   = out_byte_ff;
   assign rsp_if.frame_length = out_len_ff;
   assign rsp_if.is_last      = out_last_ff;

endmodule

// ===== sv/lpd_checker.sv =====
// Port-level checks for the deframer and the bind that attaches them.
`timescale 1ns / 1ps

module lpd_checker #(
   parameter int BUFFER_BYTES = 64,
   parameter int HEADER_BYTES = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_ready,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [lpd_pkg::BYTE_W-1:0] frame_byte,
   input  logic [lpd_pkg::FLEN_W-1:0] frame_length,
   input  logic                       is_last
);
   import lpd_pkg::*;

   logic [FLEN_W-1:0] beat_ff;
   logic              rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // Bytes of the current frame already transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else if (rsp_fire) begin
         beat_ff <= is_last ? '0 : beat_ff + FLEN_W'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_byte) &&
         $stable(frame_length) && $stable(is_last))
      else $error("result changed while stalled");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (frame_length >= FLEN_W'(HEADER_BYTES)) &&
         ({1'b0, frame_length} <= (FLEN_W + 1)'(BUFFER_BYTES)))
      else $error("frame length out of range");

   a_busy_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_last |-> !req_ready)
      else $error("input taken in the middle of a frame replay");

   a_last_count: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> ((({1'b0, beat_ff} + (FLEN_W + 1)'(1)) == {1'b0, frame_length})
         == is_last))
      else $error("last marker does not match frame length");

endmodule

bind length_prefixed_deframer lpd_checker #(
   .BUFFER_BYTES (BUFFER_BYTES),
   .HEADER_BYTES (HEADER_BYTES)
) u_lpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .frame_byte   (rsp_if.frame_byte),
   .frame_length (rsp_if.frame_length),
   .is_last      (rsp_if.is_last)
);

// ===== dv/tb_length_prefixed_deframer.sv =====
// Self-checking testbench for the length-prefixed deframer: directed table, then random frames.
`timescale 1ns / 1ps

module tb_length_prefixed_deframer;
   import lpd_pkg::*;

   localparam int BUFFER_BYTES  = 64;
   localparam int HEADER_BYTES  = 4;
   localparam int IDLE_PCT      = 29;
   localparam int RANDOM_ITEMS  = 500;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DIR_ROWS      = 25;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [FLEN_W-1:0] frame_length;
      logic              is_last;
   } frame_beat_type;

   // one pushed or clear command, with the number of frame bytes it releases
   typedef struct packed {
      lpd_cmd_type       cmd;
      logic [BYTE_W-1:0] data;
      int                results;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // shortest legal frame right after reset
      '{CMD_PUSH,  8'h04, 0}, '{CMD_PUSH,  8'h00, 0}, '{CMD_PUSH,  8'hFF, 0},
      '{CMD_PUSH,  8'h00, 4},
      // length below the header size: dropped
      '{CMD_PUSH,  8'h03, 0}, '{CMD_PUSH,  8'h00, 0}, '{CMD_PUSH,  8'h11, 0},
      '{CMD_PUSH,  8'h22, 0},
      // length one above the buffer: dropped
      '{CMD_PUSH,  8'h41, 0}, '{CMD_PUSH,  8'h00, 0}, '{CMD_PUSH,  8'h33, 0},
      '{CMD_PUSH,  8'h44, 0},
      // low byte legal but high byte set: full 16 bits compared, dropped
      '{CMD_PUSH,  8'h04, 0}, '{CMD_PUSH,  8'h01, 0}, '{CMD_PUSH,  8'h55, 0},
      '{CMD_PUSH,  8'h66, 0},
      // clear in the middle of a header, then clear while empty
      '{CMD_PUSH,  8'h05, 0}, '{CMD_PUSH,  8'h00, 0}, '{CMD_CLEAR, 8'h00, 0},
      '{CMD_CLEAR, 8'hFF, 0},
      '{CMD_PUSH,  8'h05, 0}, '{CMD_PUSH,  8'h00, 0}, '{CMD_PUSH,  8'h80, 0},
      '{CMD_PUSH,  8'h7F, 0}, '{CMD_PUSH,  8'hFF, 5}
   };

   logic clock = 1'b0;
   logic reset;

   lpd_req_if req_ch ();
   lpd_rsp_if rsp_ch ();

   length_prefixed_deframer #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver copy of the block state
   logic [BYTE_W-1:0] rx_store [BUFFER_BYTES];
   int unsigned       rx_count = 0;
   frame_beat_type    frame_beats_due [$];

   int unsigned    items_sent   = 0;
   int unsigned    mismatches   = 0;
   bit             steady_flow  = 1'b0;
   bit             rsp_hold_due = 1'b0;
   frame_beat_type got_beat;
   frame_beat_type want_beat;

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatches++;
   endtask

   // apply one transfer to the receiver copy, queue the frame bytes it releases
   function automatic int absorb_item(input lpd_cmd_type cmd, input logic [BYTE_W-1:0] data);
      logic [HDR_LEN_W-1:0] hdr_len;
      frame_beat_type       beat;
      int unsigned          k;
      if (cmd == CMD_CLEAR) begin
         for (k = 0; k < BUFFER_BYTES; k++) rx_store[k] = '0;
         rx_count = 0;
         return 0;
      end
      if (rx_count >= BUFFER_BYTES) rx_count = 0;
      rx_store[rx_count] = data;
      rx_count++;
      if (rx_count < HEADER_BYTES) return 0;
      hdr_len = {rx_store[1], rx_store[0]};
      if (hdr_len < HEADER_BYTES || hdr_len > BUFFER_BYTES) begin
         rx_count = 0;
         return 0;
      end
      if (rx_count < hdr_len) return 0;
      for (k = 0; k < hdr_len; k++) begin
         beat.frame_byte   = rx_store[k];
         beat.frame_length = hdr_len[FLEN_W-1:0];
         beat.is_last      = (k + 1 == hdr_len);
         frame_beats_due.push_back(beat);
      end
      rx_count = 0;
      return int'(hdr_len);
   endfunction

   function automatic int unsigned frame_len_pick();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(HEADER_BYTES, 16);
      if (r < 97) return $urandom_range(17, BUFFER_BYTES - 1);
      return BUFFER_BYTES;
   endfunction

   task automatic send_item(input lpd_cmd_type cmd, input logic [BYTE_W-1:0] data,
                            output int beats);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.rx_byte <= data;
      do @(posedge clock); while (!req_ch.ready);
      beats = absorb_item(cmd, data);
      items_sent++;
   endtask

   // push the first 'cut' bytes of a well-formed frame of 'len' bytes
   task automatic send_frame(input int unsigned len, input int unsigned cut);
      int                beats;
      int unsigned       k;
      logic [BYTE_W-1:0] data;
      for (k = 0; k < cut; k++) begin
         if (k == 0)      data = len[BYTE_W-1:0];
         else if (k == 1) data = '0;
         else             data = BYTE_W'($urandom_range(255));
         send_item(CMD_PUSH, data, beats);
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (frame_beats_due.size() != 0) @(posedge clock);
   endtask

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_due) begin
            rsp_hold_due = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_beat = '{rsp_ch.frame_byte, rsp_ch.frame_length, rsp_ch.is_last};
         if (frame_beats_due.size() == 0) begin
            report_mismatch($sformatf("unexpected frame byte %02h", got_beat.frame_byte));
         end else begin
            want_beat = frame_beats_due.pop_front();
            if (got_beat.frame_byte !== want_beat.frame_byte)
               report_mismatch($sformatf("frame_byte %02h, want %02h",
                                         got_beat.frame_byte, want_beat.frame_byte));
            if (got_beat.frame_length !== want_beat.frame_length)
               report_mismatch($sformatf("frame_length %0d, want %0d",
                                         got_beat.frame_length, want_beat.frame_length));
            if (got_beat.is_last !== want_beat.is_last)
               report_mismatch($sformatf("is_last %0b, want %0b",
                                         got_beat.is_last, want_beat.is_last));
         end
      end
   end

   initial begin
      #4_000_000;
      $display("[length_prefixed_deframer] ERROR");
      $finish;
   end

   initial begin
      int                beats;
      int                r;
      int unsigned       kind;
      int unsigned       len;
      int unsigned       n;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      bit                hold_done;
      bit                pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_PUSH;
      req_ch.rx_byte <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIR_ROWS; r++) begin
         send_item(DIR_TABLE[r].cmd, DIR_TABLE[r].data, beats);
         if (beats != DIR_TABLE[r].results)
            report_mismatch($sformatf("row %0d releases %0d bytes, table has %0d",
                                      r, beats, DIR_TABLE[r].results));
      end

      // largest frame first, then mostly well-formed traffic
      send_frame(BUFFER_BYTES, BUFFER_BYTES);
      while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
         if (!hold_done && items_sent >= 150) begin
            hold_done    = 1'b1;
            rsp_hold_due = 1'b1;
            send_frame(BUFFER_BYTES, BUFFER_BYTES);
         end
         if (!pause_done && items_sent >= 300) begin
            pause_done = 1'b1;
            drain_results();
         end
         steady_flow = (items_sent >= 380 && items_sent < 480);
         kind = $urandom_range(99);
         if (kind < 75) begin
            len = frame_len_pick();
            send_frame(len, len);
         end else if (kind < 85) begin
            // bad length field; the fourth byte empties the receiver
            case ($urandom_range(2))
               0: begin
                  b0 = BYTE_W'($urandom_range(HEADER_BYTES - 1));
                  b1 = '0;
               end
               1: begin
                  b0 = BYTE_W'($urandom_range(BUFFER_BYTES + 1, 255));
                  b1 = '0;
               end
               default: begin
                  b0 = BYTE_W'($urandom_range(255));
                  b1 = BYTE_W'($urandom_range(1, 255));
               end
            endcase
            send_item(CMD_PUSH, b0, beats);
            send_item(CMD_PUSH, b1, beats);
            send_item(CMD_PUSH, BYTE_W'($urandom_range(255)), beats);
            send_item(CMD_PUSH, BYTE_W'($urandom_range(255)), beats);
         end else if (kind < 93) begin
            len = frame_len_pick();
            send_frame(len, $urandom_range(1, len - 1));
            send_item(CMD_CLEAR, BYTE_W'($urandom_range(255)), beats);
         end else begin
            n = $urandom_range(1, 6);
            repeat (n)
               send_item(lpd_cmd_type'(($urandom_range(99) < 20) ? CMD_CLEAR : CMD_PUSH),
                         BYTE_W'($urandom_range(255)), beats);
            send_item(CMD_CLEAR, BYTE_W'($urandom_range(255)), beats);
         end
      end

      steady_flow = 1'b0;
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("[length_prefixed_deframer] OK");
      else
         $display("[length_prefixed_deframer] ERROR");
      $finish;
   end

endmodule
